// File: design/wsls_pkg.sv
package wsls_pkg;

    // point coordinate width
    localparam int COORD_BITS = 12;
    // window length and shortest contour that closes a segment
    localparam int WIN_LEN        = 9;
    localparam int MIN_SEG_POINTS = 5;
    localparam int SEEN_W         = $clog2(WIN_LEN + 1);
    localparam int IDX_W          = $clog2(WIN_LEN);

    // window sums and moment widths
    localparam int SUM_W = COORD_BITS + 4;
    localparam int MOM_W = 2 * COORD_BITS + 8;
    // shared multiplier operand and product widths
    localparam int MUL_W = MOM_W + 1;
    localparam int PRD_W = 2 * MUL_W;
    localparam int DIS_W = PRD_W + 1;

    // threshold register
    localparam int THR_W   = 16;
    localparam int THR_RST = 26;
    localparam int K_W     = THR_W + 7;

    // result write-back targets of the shared multiplier
    typedef enum logic [3:0] {
        DST_NONE,
        DST_SXX,
        DST_SYY,
        DST_SXY,
        DST_QX,
        DST_QY,
        DST_QXY,
        DST_DSET,
        DST_DADD,
        DST_T2
    } dst_t;

endpackage

// File: design/wsls_mul.sv
module wsls_mul (
    input  logic                         clk,
    input  logic [wsls_pkg::MUL_W-1:0]   op_a,
    input  logic [wsls_pkg::MUL_W-1:0]   op_b,
    output logic [wsls_pkg::PRD_W-1:0]   product
);
    import wsls_pkg::*;

    logic [PRD_W-1:0] product_reg;

    // one registered multiply per cycle
    always_ff @(posedge clk)
    begin
        product_reg <= PRD_W'(op_a) * PRD_W'(op_b);
    end

    assign product = product_reg;

endmodule

// File: design/window_straightness_line_splitter_core.sv
// Window straightness line splitter.
// Input channel (in_valid/in_ready): one contour point per request, with
// last_point set on the final point of the contour. Output channel
// (out_valid/out_ready): line segments, at most two per point, a split
// segment first and then the closing segment (final_segment high).
// Config: cfg_wr_en/cfg_wr_data write the 16-bit straightness threshold
// (1/256 units); write only while the block is idle.
// While fewer than nine points are held, a point goes from the accept
// straight to the output state. With a full window a point passes the
// accept, the window moments through the one shared 33x33 multiplier,
// further multiplier and compare steps, then the output state, which loads
// the first result and then a second one if there is one.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next point unless a new result must be
// loaded, in which case the sequencer holds until out_ready.
// Reset clears window, counters, segment state and sets the threshold to 26.
module window_straightness_line_splitter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wsls_pkg::COORD_BITS-1:0]   point_x,
    input  logic [wsls_pkg::COORD_BITS-1:0]   point_y,
    input  logic                              last_point,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wsls_pkg::COORD_BITS-1:0]   start_x,
    output logic [wsls_pkg::COORD_BITS-1:0]   start_y,
    output logic [wsls_pkg::COORD_BITS-1:0]   end_x,
    output logic [wsls_pkg::COORD_BITS-1:0]   end_y,
    output logic                              final_segment,
    input  logic                              cfg_wr_en,
    input  logic [wsls_pkg::THR_W-1:0]        cfg_wr_data
);
    import wsls_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [5:0] STEP_ACC_END = 6'd26;
    localparam logic [5:0] STEP_QX      = 6'd27;
    localparam logic [5:0] STEP_QY      = 6'd28;
    localparam logic [5:0] STEP_QXY     = 6'd29;
    localparam logic [5:0] STEP_ABC     = 6'd31;
    localparam logic [5:0] STEP_DAB     = 6'd32;
    localparam logic [5:0] STEP_DC      = 6'd33;
    localparam logic [5:0] STEP_T       = 6'd34;
    localparam logic [5:0] STEP_DECIDE  = 6'd36;

    logic [1:0]             state_reg;
    logic [5:0]             cnt_reg;
    logic [1:0]             phase_reg;
    logic [COORD_BITS-1:0]  win_x_reg [WIN_LEN];
    logic [COORD_BITS-1:0]  win_y_reg [WIN_LEN];
    logic [SEEN_W-1:0]      seen_reg;
    logic [SEEN_W-1:0]      seen_next;
    logic [COORD_BITS-1:0]  seg_sx_reg, seg_sy_reg, seg_ex_reg, seg_ey_reg;
    logic                   end_valid_reg;
    logic [COORD_BITS-1:0]  pt_x_reg, pt_y_reg;
    logic                   last_reg;
    logic                   split_pend_reg, close_pend_reg;
    logic [COORD_BITS-1:0]  sp_sx_reg, sp_sy_reg, sp_ex_reg, sp_ey_reg;
    logic [THR_W-1:0]       thr_reg;

    logic [SUM_W-1:0]       sx_reg, sy_reg;
    logic [MOM_W-1:0]       sxx_reg, syy_reg, sxy_reg;
    logic [MOM_W-1:0]       qx_reg, qy_reg, qxy_reg;
    logic [MOM_W-1:0]       a_reg, b_reg, c_reg;
    logic [DIS_W-1:0]       d_reg;
    logic [PRD_W-1:0]       t2_reg;
    dst_t                   dst_reg, dst_next;

    logic [MUL_W-1:0]       op_a, op_b;
    logic [PRD_W-1:0]       product;

    logic                   ov_reg;
    logic [COORD_BITS-1:0]  o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic                   o_fin_reg;
    logic                   out_free;
    logic                   out_load;
    logic                   accept;

    logic [MOM_W-1:0]       m9xx, m9yy, m9xy;
    logic [MUL_W-1:0]       s_sum, t_val, ab_diff;
    logic [K_W-1:0]         k_val;
    logic [K_W-8:0]         m_val;
    logic                   straight;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !ov_reg || out_ready;
    assign out_load = (state_reg == ST_OUT) && (split_pend_reg || close_pend_reg) && out_free;
    assign seen_next = (seen_reg < SEEN_W'(WIN_LEN)) ? seen_reg + 1'b1 : seen_reg;

    wsls_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // moment and decision arithmetic
    always_comb
    begin
        m9xx    = (sxx_reg << 3) + sxx_reg;
        m9yy    = (syy_reg << 3) + syy_reg;
        m9xy    = (sxy_reg << 3) + sxy_reg;
        s_sum   = MUL_W'(a_reg) + MUL_W'(b_reg);
        k_val   = (K_W'(thr_reg) << 6) + (K_W'(thr_reg) << 4) + K_W'(thr_reg);
        m_val   = (thr_reg != '0) ? (K_W-7)'((k_val - 1'b1) >> 7) : '0;
        t_val   = s_sum - MUL_W'(m_val);
        ab_diff = (a_reg >= b_reg) ? MUL_W'(a_reg - b_reg) : MUL_W'(b_reg - a_reg);
        straight = (thr_reg != '0) &&
                   ((s_sum <= MUL_W'(m_val)) || (DIS_W'(t2_reg) <= d_reg));
    end

    // multiplier operand select by step
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        dst_next = DST_NONE;
        if (state_reg == ST_CALC)
        begin
            if (cnt_reg <= STEP_ACC_END)
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        op_a = MUL_W'(win_x_reg[0]);
                        op_b = MUL_W'(win_x_reg[0]);
                        dst_next = DST_SXX;
                    end
                    2'd1:
                    begin
                        op_a = MUL_W'(win_y_reg[0]);
                        op_b = MUL_W'(win_y_reg[0]);
                        dst_next = DST_SYY;
                    end
                    default:
                    begin
                        op_a = MUL_W'(win_x_reg[0]);
                        op_b = MUL_W'(win_y_reg[0]);
                        dst_next = DST_SXY;
                    end
                endcase
            end
            else
            begin
                case (cnt_reg)
                    STEP_QX:
                    begin
                        op_a = MUL_W'(sx_reg);
                        op_b = MUL_W'(sx_reg);
                        dst_next = DST_QX;
                    end
                    STEP_QY:
                    begin
                        op_a = MUL_W'(sy_reg);
                        op_b = MUL_W'(sy_reg);
                        dst_next = DST_QY;
                    end
                    STEP_QXY:
                    begin
                        op_a = MUL_W'(sx_reg);
                        op_b = MUL_W'(sy_reg);
                        dst_next = DST_QXY;
                    end
                    STEP_DAB:
                    begin
                        op_a = ab_diff;
                        op_b = ab_diff;
                        dst_next = DST_DSET;
                    end
                    STEP_DC:
                    begin
                        op_a = {c_reg, 1'b0};
                        op_b = {c_reg, 1'b0};
                        dst_next = DST_DADD;
                    end
                    STEP_T:
                    begin
                        op_a = t_val;
                        op_b = t_val;
                        dst_next = DST_T2;
                    end
                    default:
                    begin
                        dst_next = DST_NONE;
                    end
                endcase
            end
        end
    end

    // product write-back, sums and a/b/c terms
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_CALC && cnt_reg <= STEP_ACC_END && phase_reg == 2'd2)
            begin
                sx_reg <= sx_reg + SUM_W'(win_x_reg[0]);
                sy_reg <= sy_reg + SUM_W'(win_y_reg[0]);
            end
            unique case (dst_reg)
                DST_SXX:  sxx_reg <= sxx_reg + MOM_W'(product);
                DST_SYY:  syy_reg <= syy_reg + MOM_W'(product);
                DST_SXY:  sxy_reg <= sxy_reg + MOM_W'(product);
                DST_QX:   qx_reg  <= MOM_W'(product);
                DST_QY:   qy_reg  <= MOM_W'(product);
                DST_QXY:  qxy_reg <= MOM_W'(product);
                DST_DSET: d_reg   <= DIS_W'(product);
                DST_DADD: d_reg   <= d_reg + DIS_W'(product);
                DST_T2:   t2_reg  <= product;
                default:  ;
            endcase
        end
        if (state_reg == ST_CALC && cnt_reg == STEP_ABC)
        begin
            a_reg <= (m9xx >= qx_reg) ? m9xx - qx_reg : qx_reg - m9xx;
            b_reg <= (m9yy >= qy_reg) ? m9yy - qy_reg : qy_reg - m9yy;
            c_reg <= (m9xy >= qxy_reg) ? m9xy - qxy_reg : qxy_reg - m9xy;
        end
    end

    // window: shift in on accept, rotate once per point during moments
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_x_reg[i] <= win_x_reg[i+1];
                win_y_reg[i] <= win_y_reg[i+1];
            end
            win_x_reg[WIN_LEN-1] <= point_x;
            win_y_reg[WIN_LEN-1] <= point_y;
        end
        else if (state_reg == ST_CALC && cnt_reg <= STEP_ACC_END && phase_reg == 2'd2)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_x_reg[i] <= win_x_reg[i+1];
                win_y_reg[i] <= win_y_reg[i+1];
            end
            win_x_reg[WIN_LEN-1] <= win_x_reg[0];
            win_y_reg[WIN_LEN-1] <= win_y_reg[0];
        end
    end

    // sequencer and segment tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= '0;
            dst_reg        <= DST_NONE;
            seen_reg       <= '0;
            seg_sx_reg     <= '0;
            seg_sy_reg     <= '0;
            seg_ex_reg     <= '0;
            seg_ey_reg     <= '0;
            end_valid_reg  <= 1'b0;
            pt_x_reg       <= '0;
            pt_y_reg       <= '0;
            last_reg       <= 1'b0;
            split_pend_reg <= 1'b0;
            close_pend_reg <= 1'b0;
            sp_sx_reg      <= '0;
            sp_sy_reg      <= '0;
            sp_ex_reg      <= '0;
            sp_ey_reg      <= '0;
            thr_reg        <= THR_W'(THR_RST);
            ov_reg         <= 1'b0;
            o_sx_reg       <= '0;
            o_sy_reg       <= '0;
            o_ex_reg       <= '0;
            o_ey_reg       <= '0;
            o_fin_reg      <= 1'b0;
        end
        else
        begin
            dst_reg <= dst_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            // output register: load wins over a drain in the same cycle
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pt_x_reg       <= point_x;
                        pt_y_reg       <= point_y;
                        last_reg       <= last_point;
                        split_pend_reg <= 1'b0;
                        close_pend_reg <= last_point &&
                                          (seen_next >= SEEN_W'(MIN_SEG_POINTS));
                        seen_reg       <= last_point ? '0 : seen_next;
                        if (seen_reg == '0)
                        begin
                            seg_sx_reg    <= point_x;
                            seg_sy_reg    <= point_y;
                            end_valid_reg <= 1'b0;
                        end
                        cnt_reg   <= '0;
                        phase_reg <= '0;
                        state_reg <= (seen_next == SEEN_W'(WIN_LEN)) ? ST_CALC : ST_OUT;
                    end
                end
                ST_CALC:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    phase_reg <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 1'b1;
                    if (cnt_reg == STEP_DECIDE)
                    begin
                        if (straight)
                        begin
                            seg_ex_reg    <= win_x_reg[0];
                            seg_ey_reg    <= win_y_reg[0];
                            end_valid_reg <= !last_reg;
                        end
                        else
                        begin
                            split_pend_reg <= end_valid_reg;
                            sp_sx_reg      <= seg_sx_reg;
                            sp_sy_reg      <= seg_sy_reg;
                            sp_ex_reg      <= seg_ex_reg;
                            sp_ey_reg      <= seg_ey_reg;
                            seg_sx_reg     <= win_x_reg[0];
                            seg_sy_reg     <= win_y_reg[0];
                            end_valid_reg  <= 1'b0;
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (split_pend_reg)
                    begin
                        if (out_free)
                        begin
                            o_sx_reg       <= sp_sx_reg;
                            o_sy_reg       <= sp_sy_reg;
                            o_ex_reg       <= sp_ex_reg;
                            o_ey_reg       <= sp_ey_reg;
                            o_fin_reg      <= 1'b0;
                            split_pend_reg <= 1'b0;
                        end
                    end
                    else if (close_pend_reg)
                    begin
                        if (out_free)
                        begin
                            o_sx_reg       <= seg_sx_reg;
                            o_sy_reg       <= seg_sy_reg;
                            o_ex_reg       <= pt_x_reg;
                            o_ey_reg       <= pt_y_reg;
                            o_fin_reg      <= 1'b1;
                            close_pend_reg <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = ov_reg;
    assign start_x       = o_sx_reg;
    assign start_y       = o_sy_reg;
    assign end_x         = o_ex_reg;
    assign end_y         = o_ey_reg;
    assign final_segment = o_fin_reg;

endmodule

// File: design/wsls_checker.sv
module wsls_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [wsls_pkg::COORD_BITS-1:0]   start_x,
    input  logic [wsls_pkg::COORD_BITS-1:0]   end_x,
    input  logic                              final_segment
);
    import wsls_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_x) && $stable(end_x)
            && $stable(final_segment))
        else $error("stalled result changed");

    // block is not ready in the cycle after each accepted point
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a request");

    // a new result is only loaded while a point is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind window_straightness_line_splitter_core wsls_checker u_wsls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_x       (start_x),
    .end_x         (end_x),
    .final_segment (final_segment)
);
